[design/ntcb_pkg.sv]
// ----------------------------------------------------------------------------
// ntcb_pkg
// shared constants, register indexes and log table helpers for the ntc block
// ----------------------------------------------------------------------------
package ntcb_pkg;

  localparam int unsigned SAMPLE_BITS_DEF     = 12;
  localparam int unsigned LOG_TABLE_DEPTH_DEF = 256;
  localparam int unsigned FRACTION_BITS_DEF   = 16;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned TEMP_W     = 11;
  localparam int unsigned RES_W      = 20;
  localparam int unsigned BETA_W     = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SOURCE_SELECT     = 3'd0,
    REG_CHANNEL_ENABLED   = 3'd1,
    REG_SERIES_RESISTANCE = 3'd2,
    REG_BETA_COEFFICIENT  = 3'd3,
    REG_NOMINAL_TYPE      = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    SRC_NONE = 2'd0,
    SRC_ADC  = 2'd1,
    SRC_BUS  = 2'd2,
    SRC_RSVD = 2'd3
  } src_sel_t;

  localparam logic [BETA_W-1:0] BETA_DEFAULT = 16'd3950;
  localparam logic [RES_W-1:0]  RNOM_10K     = 20'd10000;
  localparam logic [RES_W-1:0]  RNOM_100K    = 20'd100000;
  localparam logic [RES_W-1:0]  RS_RESET     = 20'd10000;

  // 100 * T0 in kelvin
  localparam int unsigned T0_X100   = 29815;
  // 100 * (T0 - 273.15) * 100
  localparam int unsigned DIFF_BETA = 250000;
  // 27315 * 29815
  localparam int unsigned DIFF_LOG  = 814396725;

  localparam int TEMP_MIN = -200;
  localparam int TEMP_MAX = 1000;

  // restoring divide, used only while building constant tables
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] dv);
    logic [63:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= dv) begin
        r = r - dv;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // ln((depth+i)/depth) in fixed point with fb fraction bits, atanh series in q30
  function automatic logic [63:0] log_entry(input int unsigned i, input int unsigned depth,
                                            input int unsigned fb);
    logic [63:0] z;
    logic [63:0] z2;
    logic [63:0] term;
    logic [63:0] sum;
    z    = udiv64(64'(i) << 30, 64'(2 * depth + i));
    z2   = (z * z) >> 30;
    term = z;
    sum  = z;
    for (int unsigned k = 1; k < 200; k++) begin
      if (term != 0) begin
        term = (term * z2) >> 30;
        sum  = sum + udiv64(term, 64'(2 * k + 1));
      end
    end
    sum = sum << 1;
    return (sum + (64'd1 << (29 - fb))) >> (30 - fb);
  endfunction

endpackage

[design/ntc_thermistor_beta_to_celsius_top.sv]
// ----------------------------------------------------------------------------
// ntc_thermistor_beta_to_celsius_top
// adc sample to degrees celsius through the thermistor beta equation
// ----------------------------------------------------------------------------
// pipeline: 22 register stages (10 arithmetic, 11 divide steps, output)
// throughput: one sample per cycle; the whole pipe advances when the output
//   register is empty or taken, so one stalled result holds every stage
// the rounding divide runs as one restoring step per stage (11 stages)
// reset (synchronous, rst_n low) empties the pipe and restores register defaults
module ntc_thermistor_beta_to_celsius_top #(
  parameter int unsigned SAMPLE_BITS     = ntcb_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned LOG_TABLE_DEPTH = ntcb_pkg::LOG_TABLE_DEPTH_DEF, // power of two
  parameter int unsigned FRACTION_BITS   = ntcb_pkg::FRACTION_BITS_DEF,
  localparam int unsigned IN_W  = ((SAMPLE_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((ntcb_pkg::TEMP_W + 2 + SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [adc_sample]
  input  logic [IN_W-1:0]                 in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [temperature_celsius, reading_valid, source_configured, raw_sample_echo]
  output logic [OUT_W-1:0]                out_tdata,
  input  logic                            cfg_we,
  input  logic [ntcb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ntcb_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ntcb_pkg::*;

  localparam int unsigned SB   = SAMPLE_BITS;
  localparam int unsigned F    = FRACTION_BITS;
  localparam int unsigned D    = LOG_TABLE_DEPTH;
  localparam int unsigned DB   = $clog2(D);
  localparam int unsigned XW   = SB + F;
  localparam int unsigned QW   = F + 1;
  localparam int unsigned NUMW = F + 1 + RES_W;
  localparam int unsigned EW   = $clog2(NUMW);
  localparam int unsigned LGW  = F + EW + 1;
  localparam int unsigned LQW  = LGW + 1;
  localparam int unsigned BDW  = F + 26;
  localparam int unsigned MW   = LQW + 31;
  localparam int unsigned DFW  = F + 40;
  localparam int unsigned NW   = F + 46;
  localparam int unsigned QB   = TEMP_W;
  localparam int unsigned DIV0 = 9;
  localparam int unsigned NST  = DIV0 + QB + 2;
  localparam int unsigned LAST = NST - 1;

  localparam logic [SB-1:0] FULL = SB'((64'd1 << SB) - 64'd1);
  localparam logic [QW-1:0] ONE  = QW'(64'd1 << F);
  localparam logic [QW-1:0] LO_Q = QW'(((64'd1 << F) + 64'd5000) / 64'd10000);
  localparam logic [QW-1:0] HI_Q = ONE - LO_Q;

  typedef logic [F-1:0] ltab_t [0:D];

  function automatic ltab_t build_ltab();
    ltab_t t;
    for (int i = 0; i <= int'(D); i++) begin
      t[i] = F'(log_entry(i, D, F));
    end
    return t;
  endfunction

  localparam ltab_t LTAB = build_ltab();

  // configuration registers
  logic [1:0]        src_sel_r;
  logic              chan_en_r;
  logic [RES_W-1:0]  rs_r;
  logic [BETA_W-1:0] beta_r;
  logic              nom_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_sel_r <= SRC_ADC;
      chan_en_r <= 1'b1;
      rs_r      <= RS_RESET;
      beta_r    <= BETA_DEFAULT;
      nom_r     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SOURCE_SELECT:     src_sel_r <= cfg_data[1:0];
        REG_CHANNEL_ENABLED:   chan_en_r <= cfg_data[0];
        REG_SERIES_RESISTANCE: rs_r      <= cfg_data[RES_W-1:0];
        REG_BETA_COEFFICIENT:  beta_r    <= cfg_data[BETA_W-1:0];
        REG_NOMINAL_TYPE:      nom_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic [BETA_W-1:0] beta_eff;
  logic [RES_W-1:0]  rnom;
  assign beta_eff = (beta_r == '0) ? BETA_DEFAULT : beta_r;
  assign rnom     = nom_r ? RNOM_100K : RNOM_10K;

  // pipeline control and sideband
  logic           ce;
  logic [NST-1:0] vld_r;
  logic [NST-1:0] ok_r;
  logic [NST-1:0] srccfg_r;
  logic [SB-1:0]  smp_r [0:NST-1];

  assign ce        = !vld_r[LAST] || out_tready;
  assign in_tready = ce;

  // stage 0: ratio estimate by reciprocal series of the full scale
  logic [SB-1:0] sample_in;
  logic [XW-1:0] x_nxt, x_r;
  logic [QW-1:0] a_nxt, a_r;
  logic [XW+1:0] asum;

  assign sample_in = in_tdata[SB-1:0];
  assign x_nxt = {sample_in, {F{1'b0}}} + XW'(FULL >> 1);
  assign asum  = (XW+2)'(x_nxt) + (XW+2)'(x_nxt >> SB) + (XW+2)'(x_nxt >> (2 * SB))
               + (XW+2)'(x_nxt >> (3 * SB));
  assign a_nxt = QW'(asum >> SB);

  // stage 1: correct the estimate and clamp
  logic [XW+1:0] rem1;
  logic [QW-1:0] qc, q_nxt, q_r;
  always_comb begin
    rem1 = (XW+2)'(x_r) - ((XW+2)'(a_r) << SB) + (XW+2)'(a_r);
    qc   = a_r + QW'(rem1 >= (XW+2)'(FULL)) + QW'(rem1 >= ((XW+2)'(FULL) << 1));
    if (qc < LO_Q)      q_nxt = LO_Q;
    else if (qc > HI_Q) q_nxt = HI_Q;
    else                q_nxt = qc;
  end

  // stage 2: numerator and denominator of the resistance ratio
  logic [NUMW-1:0] v2_nxt [0:1];
  logic [NUMW-1:0] v2_r   [0:1];
  assign v2_nxt[0] = NUMW'(q_r) * NUMW'(rs_r);
  assign v2_nxt[1] = NUMW'(ONE - q_r) * NUMW'(rnom);

  // stages 3..5: two log lanes
  logic [EW-1:0]      e3_nxt [0:1];
  logic [EW-1:0]      e3_r   [0:1];
  logic [NUMW-1:0]    v3_r   [0:1];
  logic [F-1:0]       lo4_nxt [0:1];
  logic [F-1:0]       hi4_nxt [0:1];
  logic [31:0]        w4_nxt  [0:1];
  logic [F-1:0]       lo4_r [0:1];
  logic [F-1:0]       hi4_r [0:1];
  logic [31:0]        w4_r  [0:1];
  logic [EW-1:0]      e4_r  [0:1];
  logic [LGW-1:0]     base5_nxt [0:1];
  logic [F+31:0]      prod5_nxt [0:1];
  logic [LGW-1:0]     base5_r [0:1];
  logic [F+31:0]      prod5_r [0:1];
  logic [LGW-1:0]     lg6 [0:1];

  for (genvar j = 0; j < 2; j++) begin : g_log
    logic [NUMW+31:0] norm;
    logic [31:0]      frac;
    logic [DB-1:0]    idx;
    logic [DB:0]      idx1;

    // leading one position, zero for a zero word
    always_comb begin
      e3_nxt[j] = '0;
      for (int b = 0; b < int'(NUMW); b++) begin
        if (v2_r[j][b]) e3_nxt[j] = EW'(b);
      end
    end

    assign norm = {v3_r[j], 32'b0} << (EW'(NUMW - 1) - e3_r[j]);
    assign frac = norm[NUMW+30 -: 32];
    assign idx  = frac[31 -: DB];
    assign idx1 = {1'b0, idx} + 1'b1;
    assign lo4_nxt[j] = LTAB[idx];
    assign hi4_nxt[j] = LTAB[idx1];
    assign w4_nxt[j]  = frac << DB;

    assign base5_nxt[j] = LGW'(e4_r[j]) * LGW'(LTAB[D]) + LGW'(lo4_r[j]);
    assign prod5_nxt[j] = (F+32)'(hi4_r[j] - lo4_r[j]) * (F+32)'(w4_r[j]);
    assign lg6[j] = base5_r[j] + LGW'((prod5_r[j] + (F+32)'(33'h0_8000_0000)) >> 32);
  end

  // stage 6: log of the resistance ratio
  logic signed [LQW-1:0] lq_nxt, lq_r;
  assign lq_nxt = $signed({1'b0, lg6[0]}) - $signed({1'b0, lg6[1]});

  // stage 7: beta denominator and log term of the numerator
  localparam logic signed [BDW-1:0] K_T0   = BDW'(T0_X100);
  localparam logic signed [MW-1:0]  K_DLOG = MW'(DIFF_LOG);
  logic signed [BDW-1:0] bden_nxt, bden_r;
  logic signed [MW-1:0]  m_nxt, m_r;
  logic [35:0]           bb_nxt, bb_r;
  assign bden_nxt = (BDW'(BDW'(beta_eff) * BDW'(100)) <<< F) + BDW'(lq_r) * K_T0;
  assign m_nxt    = MW'(lq_r) * K_DLOG;
  assign bb_nxt   = 36'(beta_eff) * 36'(DIFF_BETA);

  // stage 8: signed dividend, divisor and rounding offset
  logic signed [DFW-1:0] diff8;
  logic [NW-1:0]         n8_nxt, d8_nxt, n8_r, d8_r;
  logic                  neg8_nxt, neg8_r, pos8;
  always_comb begin
    diff8    = (DFW'(bb_r) <<< F) - DFW'(m_r);
    neg8_nxt = diff8[DFW-1];
    d8_nxt   = NW'(bden_r) * NW'(100);
    n8_nxt   = (neg8_nxt ? NW'(-diff8) : NW'(diff8)) + NW'(bden_r) * NW'(50);
    pos8     = !bden_r[BDW-1] && (bden_r != '0);
  end

  // stages 9..: quotient overflow check and one restoring step per stage
  logic [NW-1:0] rem_r [0:QB];
  logic [NW-1:0] dv_r  [0:QB];
  logic [QB-1:0] quo_r [0:QB];
  logic          neg_r [0:QB];
  logic          ovf_r [0:QB];

  for (genvar j = 1; j <= QB; j++) begin : g_div
    logic [NW-1:0] sh;
    assign sh = dv_r[j-1] << (QB - j);
    always_ff @(posedge clk) begin
      if (ce) begin
        dv_r[j]  <= dv_r[j-1];
        neg_r[j] <= neg_r[j-1];
        ovf_r[j] <= ovf_r[j-1];
        if (rem_r[j-1] >= sh) begin
          rem_r[j] <= rem_r[j-1] - sh;
          quo_r[j] <= quo_r[j-1] | (QB'(1) << (QB - j));
        end else begin
          rem_r[j] <= rem_r[j-1];
          quo_r[j] <= quo_r[j-1];
        end
      end
    end
  end

  // final stage: saturate and pack
  logic signed [TEMP_W-1:0] temp_nxt;
  logic [OUT_W-1:0]         out_nxt, out_r;
  always_comb begin
    temp_nxt = '0;
    if (ok_r[LAST-1]) begin
      if (neg_r[QB]) begin
        if (ovf_r[QB] || quo_r[QB] > QB'(-TEMP_MIN)) temp_nxt = TEMP_W'(TEMP_MIN);
        else temp_nxt = -$signed(quo_r[QB]);
      end else begin
        if (ovf_r[QB] || quo_r[QB] > QB'(TEMP_MAX)) temp_nxt = TEMP_W'(TEMP_MAX);
        else temp_nxt = $signed(quo_r[QB]);
      end
    end
    out_nxt = OUT_W'({(ok_r[LAST-1] ? smp_r[LAST-1] : SB'(0)), srccfg_r[LAST-1],
                      ok_r[LAST-1], temp_nxt});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ce) begin
      vld_r <= {vld_r[NST-2:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      smp_r[0]    <= sample_in;
      ok_r[0]     <= (src_sel_r == SRC_ADC) && chan_en_r && (rs_r != '0);
      srccfg_r[0] <= (src_sel_r != SRC_NONE);
      for (int k = 1; k < int'(NST); k++) begin
        smp_r[k]    <= smp_r[k-1];
        srccfg_r[k] <= srccfg_r[k-1];
        // the beta denominator must be positive for a valid reading
        if (k == int'(DIV0) - 1) ok_r[k] <= ok_r[k-1] && pos8;
        else                     ok_r[k] <= ok_r[k-1];
      end

      x_r <= x_nxt;
      a_r <= a_nxt;
      q_r <= q_nxt;
      for (int j = 0; j < 2; j++) begin
        v2_r[j]    <= v2_nxt[j];
        v3_r[j]    <= v2_r[j];
        e3_r[j]    <= e3_nxt[j];
        lo4_r[j]   <= lo4_nxt[j];
        hi4_r[j]   <= hi4_nxt[j];
        w4_r[j]    <= w4_nxt[j];
        e4_r[j]    <= e3_r[j];
        base5_r[j] <= base5_nxt[j];
        prod5_r[j] <= prod5_nxt[j];
      end
      lq_r   <= lq_nxt;
      bden_r <= bden_nxt;
      m_r    <= m_nxt;
      bb_r   <= bb_nxt;
      n8_r   <= n8_nxt;
      d8_r   <= d8_nxt;
      neg8_r <= neg8_nxt;

      rem_r[0] <= n8_r;
      dv_r[0]  <= d8_r;
      quo_r[0] <= '0;
      neg_r[0] <= neg8_r;
      ovf_r[0] <= n8_r >= (d8_r << QB);

      out_r <= out_nxt;
    end
  end

  assign out_tvalid = vld_r[LAST];
  assign out_tdata  = out_r;

endmodule

[design/ntcb_chk.sv]
// ----------------------------------------------------------------------------
// ntcb_chk
// port-level checks on the ntc temperature block
// ----------------------------------------------------------------------------
module ntcb_chk #(
  parameter int unsigned OUT_W = 32
) (
  input logic             clk,
  input logic             rst_n,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);
  import ntcb_pkg::*;

  logic signed [TEMP_W-1:0] temp;
  assign temp = $signed(out_tdata[TEMP_W-1:0]);

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result after reset");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[TEMP_W] |-> temp == 0 && out_tdata[OUT_W-1:TEMP_W+2] == '0)
    else $error("invalid reading carries data");

  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> temp >= TEMP_W'(TEMP_MIN) && temp <= TEMP_W'(TEMP_MAX))
    else $error("temperature out of range");

endmodule

bind ntc_thermistor_beta_to_celsius_top ntcb_chk #(.OUT_W(OUT_W)) u_ntcb_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
